[hw/rtl/contiguous_fit_allocator_core_defines.svh]
// Assertion macros for the contiguous fit allocator.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfa assertion failed");
`define CFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfa assertion failed");
`else
`define CFA_ASSERT_NOW(lbl, ante, cons)
`define CFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/cfa_pkg.sv]
// Shared types and constants of the contiguous fit allocator.
`default_nettype none
package cfa_pkg;
  localparam int REQ_TYPE_W   = 1;
  localparam int OWNER_W      = 6;
  localparam int SIZE_W       = 11;
  localparam int HOLD_W       = 16;
  localparam int STATUS_W     = 3;
  localparam int START_W      = 10;
  localparam int LEN_W        = 11;
  localparam int COUNT_W      = 10;
  localparam int POLICY_W     = 2;
  localparam int TIME_W       = 32;
  localparam int MAX_RELEASES = 63;
  localparam int REL_W        = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC     = 3'd0,
    ST_NOFIT     = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_TICK_DONE = 3'd3,
    ST_BAD       = 3'd4
  } status_t;

  localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
endpackage
`default_nettype wire

[hw/rtl/cfa_req_if.sv]
// Request channel: valid/ready plus the request word.
`default_nettype none
interface cfa_req_if
  import cfa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [OWNER_W-1:0]    owner_id;
  logic [SIZE_W-1:0]     seg_size;
  logic [HOLD_W-1:0]     hold_ticks;
  modport source (output valid, req_type, owner_id, seg_size, hold_ticks, input ready);
  modport sink (input valid, req_type, owner_id, seg_size, hold_ticks, output ready);
endinterface
`default_nettype wire

[hw/rtl/cfa_rsp_if.sv]
// Result channel: valid/ready plus the result word.
`default_nettype none
interface cfa_rsp_if
  import cfa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OWNER_W-1:0]  owner_out;
  logic [START_W-1:0]  seg_start;
  logic [LEN_W-1:0]    seg_len;
  logic [COUNT_W-1:0]  hole_count;
  logic [LEN_W-1:0]    largest_hole;
  logic [LEN_W-1:0]    smallest_hole;
  logic                last;
  modport source (output valid, status, owner_out, seg_start, seg_len, hole_count,
                  largest_hole, smallest_hole, last, input ready);
  modport sink (input valid, status, owner_out, seg_start, seg_len, hole_count,
                largest_hole, smallest_hole, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/cfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/contiguous_fit_allocator_core.sv]
// Top level of the contiguous fit allocator.
`default_nettype none
`include "contiguous_fit_allocator_core_defines.svh"
// Contiguous segment allocator over a map of MEM_UNITS units, one occupancy bit
// per unit in a RAM, with owner records (start, length, expiry) in a second RAM.
// One request is handled at a time; a finished result sits in the output
// register while the next request is taken. After reset a clearing pass
// zeroes the map before the first request is accepted. All map scans run
// through one hole scanner that walks the map one unit per cycle. An
// allocate runs a placement scan, a fill and a statistics scan; a no-fit a
// placement scan and a statistics scan; a bad request only a statistics
// scan. A tick runs, per released segment, an owner sweep, an unfill and a
// statistics scan; its closing result follows a statistics scan, after an
// owner sweep unless MAX_RELEASES segments were already released.
// Each result word also waits while the previous one sits unaccepted in the
// output register.
module contiguous_fit_allocator_core
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS  = 1024,
  parameter int MAX_OWNERS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [POLICY_W-1:0] cfg_wr_data,
  cfa_req_if.sink                  req,
  cfa_rsp_if.source                rsp
);
  localparam int AW  = $clog2(MEM_UNITS);
  localparam int CW  = $clog2(MEM_UNITS + 1);
  localparam int OW  = $clog2(MAX_OWNERS);
  localparam int OCW = $clog2(MAX_OWNERS + 1);
  localparam int DW  = AW + CW + TIME_W;
  localparam logic [AW-1:0] LAST_UNIT  = AW'(MEM_UNITS - 1);
  localparam logic [OW-1:0] LAST_OWNER = OW'(MAX_OWNERS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PICK, S_DECIDE, S_FILL, S_LOOP, S_OWN, S_OWN_DONE,
    S_UNFILL, S_STAT, S_EMIT
  } state_t;

  state_t                state;
  logic [POLICY_W-1:0]   policy;
  logic [TIME_W-1:0]     now_ticks;
  logic [MAX_OWNERS-1:0] active;
  logic [OWNER_W-1:0]    r_owner;
  logic [CW-1:0]         need;
  logic [HOLD_W-1:0]     r_hold;
  logic [REL_W-1:0]      n_rel;

  // map scanner
  logic [CW-1:0] iss_cnt;
  logic          pv;
  logic [AW-1:0] pidx;
  logic          in_hole;
  logic [AW-1:0] run_start;
  logic [CW-1:0] run_len;
  logic [CW-1:0] h_cnt, h_big, h_small;
  logic          pk_found;
  logic [AW-1:0] pk_start;
  logic [CW-1:0] pk_len;

  // owner sweep
  logic [OCW-1:0] o_iss;
  logic           opv;
  logic [OW-1:0]  oidx;
  logic           sel_found;
  logic [OW-1:0]  sel;
  logic [AW-1:0]  sel_start;
  logic [CW-1:0]  sel_len;

  logic [CW-1:0] f_ptr, f_cnt;

  status_t              res_status;
  logic [OWNER_W-1:0]   res_owner;
  logic [AW-1:0]        res_start;
  logic [CW-1:0]        res_len;
  logic                 res_last;

  logic                rsp_valid;
  logic [STATUS_W-1:0] o_status;
  logic [OWNER_W-1:0]  o_owner;
  logic [START_W-1:0]  o_start;
  logic [LEN_W-1:0]    o_len;
  logic [COUNT_W-1:0]  o_cnt;
  logic [LEN_W-1:0]    o_big, o_small;
  logic                o_last;

  logic          bm_we, bm_rdata;
  logic          om_we;
  logic [DW-1:0] om_wdata, om_rdata;
  logic [TIME_W-1:0] od_exp;
  logic [CW-1:0]     od_len;
  logic [AW-1:0]     od_start;

  logic          u_free, u_last, h_close, scan_done, pick_take, fit_ok;
  logic [AW-1:0] cur_start, h_s;
  logic [CW-1:0] cur_len, h_l;
  logic          cand, own_done, req_bad;

  assign bm_we = (state == S_CLEAR) || (state == S_FILL) || (state == S_UNFILL);

  cfa_ram #(.WIDTH(1), .DEPTH(MEM_UNITS)) u_map (
    .clk   (clk),
    .we    (bm_we),
    .waddr (f_ptr[AW-1:0]),
    .wdata (state == S_FILL),
    .raddr (iss_cnt[AW-1:0]),
    .rdata (bm_rdata)
  );

  assign fit_ok   = pk_found && (pk_len >= need);
  assign om_we    = (state == S_DECIDE) && fit_ok;
  assign om_wdata = {pk_start, need, now_ticks + TIME_W'(r_hold)};

  cfa_ram #(.WIDTH(DW), .DEPTH(MAX_OWNERS)) u_owners (
    .clk   (clk),
    .we    (om_we),
    .waddr (r_owner[OW-1:0]),
    .wdata (om_wdata),
    .raddr (o_iss[OW-1:0]),
    .rdata (om_rdata)
  );

  assign od_exp   = om_rdata[TIME_W-1:0];
  assign od_len   = om_rdata[TIME_W +: CW];
  assign od_start = om_rdata[TIME_W+CW +: AW];

  // hole detection on the bit coming back from the map
  always_comb begin
    u_free    = !bm_rdata;
    u_last    = (pidx == LAST_UNIT);
    cur_start = in_hole ? run_start : pidx;
    cur_len   = in_hole ? run_len + CW'(1) : CW'(1);
    h_close   = pv && ((!u_free && in_hole) || (u_free && u_last));
    h_s       = u_free ? cur_start : run_start;
    h_l       = u_free ? cur_len : run_len;
    scan_done = pv && u_last;
    case (policy)
      POL_BEST:  pick_take = (h_l >= need) && (!pk_found || h_l < pk_len);
      POL_WORST: pick_take = !pk_found || (h_l > pk_len);
      default:   pick_take = (h_l >= need) && !pk_found;
    endcase
  end

  assign cand = opv && active[oidx] && (od_exp <= now_ticks) &&
                (!sel_found || od_start < sel_start);
  assign own_done = opv && (oidx == LAST_OWNER);
  assign req_bad = (32'(req.owner_id) >= MAX_OWNERS) || active[req.owner_id[OW-1:0]] ||
                   (req.seg_size == '0) || (32'(req.seg_size) > MEM_UNITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      policy    <= '0;
      now_ticks <= '0;
      active    <= '0;
      rsp_valid <= 1'b0;
      n_rel     <= '0;
      f_ptr     <= '0;
      iss_cnt   <= '0;
      pv        <= 1'b0;
      o_iss     <= '0;
      opv       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        policy <= cfg_wr_data;
      end
      // in S_EMIT the output register is handled below
      if (rsp.ready && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end

      if ((state == S_PICK) || (state == S_STAT)) begin
        if (32'(iss_cnt) < MEM_UNITS) begin
          iss_cnt <= iss_cnt + CW'(1);
        end
        pv   <= 32'(iss_cnt) < MEM_UNITS;
        pidx <= iss_cnt[AW-1:0];
        if (pv) begin
          in_hole   <= u_free && !u_last;
          run_start <= cur_start;
          run_len   <= cur_len;
        end
        if (h_close) begin
          h_cnt <= h_cnt + CW'(1);
          if ((h_cnt == '0) || (h_l > h_big)) h_big <= h_l;
          if ((h_cnt == '0) || (h_l < h_small)) h_small <= h_l;
          if ((state == S_PICK) && pick_take) begin
            pk_found <= 1'b1;
            pk_start <= h_s;
            pk_len   <= h_l;
          end
        end
      end

      if (state == S_OWN) begin
        if (32'(o_iss) < MAX_OWNERS) begin
          o_iss <= o_iss + OCW'(1);
        end
        opv  <= 32'(o_iss) < MAX_OWNERS;
        oidx <= o_iss[OW-1:0];
        if (cand) begin
          sel_found <= 1'b1;
          sel       <= oidx;
          sel_start <= od_start;
          sel_len   <= od_len;
        end
      end

      case (state)
        S_CLEAR: begin
          f_ptr <= f_ptr + CW'(1);
          if (f_ptr[AW-1:0] == LAST_UNIT) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            r_owner <= req.owner_id;
            need    <= CW'(req.seg_size);
            r_hold  <= req.hold_ticks;
            iss_cnt <= '0; pv <= 1'b0; in_hole <= 1'b0;
            h_cnt <= '0; h_big <= '0; h_small <= '0; pk_found <= 1'b0;
            if (req.req_type != REQ_ALLOC) begin
              n_rel <= '0;
              state <= S_LOOP;
            end else if (req_bad) begin
              res_status <= ST_BAD;
              res_owner  <= req.owner_id;
              res_start  <= '0;
              res_len    <= '0;
              res_last   <= 1'b1;
              state      <= S_STAT;
            end else begin
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          if (scan_done) state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_owner <= r_owner;
          res_last  <= 1'b1;
          iss_cnt <= '0; pv <= 1'b0; in_hole <= 1'b0;
          h_cnt <= '0; h_big <= '0; h_small <= '0;
          if (fit_ok) begin
            active[r_owner[OW-1:0]] <= 1'b1;
            res_status <= ST_ALLOC;
            res_start  <= pk_start;
            res_len    <= need;
            f_ptr      <= CW'(pk_start);
            f_cnt      <= need;
            state      <= S_FILL;
          end else begin
            res_status <= ST_NOFIT;
            res_start  <= '0;
            res_len    <= '0;
            state      <= S_STAT;
          end
        end
        S_FILL, S_UNFILL: begin
          f_ptr <= f_ptr + CW'(1);
          f_cnt <= f_cnt - CW'(1);
          if (f_cnt == CW'(1)) state <= S_STAT;
        end
        S_LOOP: begin
          if (32'(n_rel) == MAX_RELEASES) begin
            res_status <= ST_TICK_DONE;
            res_owner <= '0; res_start <= '0; res_len <= '0; res_last <= 1'b1;
            iss_cnt <= '0; pv <= 1'b0; in_hole <= 1'b0;
            h_cnt <= '0; h_big <= '0; h_small <= '0;
            state <= S_STAT;
          end else begin
            o_iss <= '0; opv <= 1'b0; sel_found <= 1'b0;
            state <= S_OWN;
          end
        end
        S_OWN: begin
          if (own_done) state <= S_OWN_DONE;
        end
        S_OWN_DONE: begin
          iss_cnt <= '0; pv <= 1'b0; in_hole <= 1'b0;
          h_cnt <= '0; h_big <= '0; h_small <= '0;
          if (sel_found) begin
            active[sel] <= 1'b0;
            res_status  <= ST_RELEASED;
            res_owner   <= OWNER_W'(sel);
            res_start   <= sel_start;
            res_len     <= sel_len;
            res_last    <= 1'b0;
            f_ptr       <= CW'(sel_start);
            f_cnt       <= sel_len;
            state       <= S_UNFILL;
          end else begin
            res_status <= ST_TICK_DONE;
            res_owner <= '0; res_start <= '0; res_len <= '0; res_last <= 1'b1;
            state <= S_STAT;
          end
        end
        S_STAT: begin
          if (scan_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            o_status  <= res_status;
            o_owner   <= res_owner;
            o_start   <= START_W'(res_start);
            o_len     <= LEN_W'(res_len);
            o_cnt     <= COUNT_W'(h_cnt);
            o_big     <= LEN_W'(h_big);
            o_small   <= LEN_W'(h_small);
            o_last    <= res_last;
            case (res_status)
              ST_RELEASED: begin
                n_rel <= n_rel + REL_W'(1);
                state <= S_LOOP;
              end
              ST_TICK_DONE: begin
                now_ticks <= now_ticks + TIME_W'(1);
                state     <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = o_status;
  assign rsp.owner_out     = o_owner;
  assign rsp.seg_start     = o_start;
  assign rsp.seg_len       = o_len;
  assign rsp.hole_count    = o_cnt;
  assign rsp.largest_hole  = o_big;
  assign rsp.smallest_hole = o_small;
  assign rsp.last          = o_last;

  `CFA_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state != S_IDLE)
  `CFA_ASSERT_NOW(a_fill_in_map, state == S_FILL || state == S_UNFILL, 32'(f_ptr) < MEM_UNITS)
  `CFA_ASSERT_NEXT(a_release_clears, state == S_OWN_DONE && sel_found, !active[sel])
  `CFA_ASSERT_NOW(a_release_not_last, state == S_EMIT && res_status == ST_RELEASED, !res_last)
endmodule
`default_nettype wire
